// ===== rtl/core/wvadsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Wavetable voice package
// Shared types, command and register codes, and fixed constants for the
// wavetable voice with its linear ADSR envelope.
// ----------------------------------------------------------------------------
package wvadsr_pkg;

  // Default wavetable depth in entries.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Command codes carried in the cmd field.
  localparam logic [2:0] CMD_SAMPLE   = 3'd0;
  localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
  localparam logic [2:0] CMD_NOTE_OFF = 3'd2;
  localparam logic [2:0] CMD_TICK     = 3'd3;
  localparam logic [2:0] CMD_TBL_WR   = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_PHASE_STEP = 3'd0;
  localparam logic [2:0] REG_GAIN       = 3'd1;
  localparam logic [2:0] REG_ATTACK_MS  = 3'd2;
  localparam logic [2:0] REG_DECAY_MS   = 3'd3;
  localparam logic [2:0] REG_SUSTAIN    = 3'd4;
  localparam logic [2:0] REG_RELEASE_MS = 3'd5;

  // Register reset values.
  localparam logic [31:0] PHASE_STEP_RST = 32'd0;
  localparam logic [15:0] GAIN_RST       = 16'd32768;
  localparam logic [15:0] ATTACK_MS_RST  = 16'd10;
  localparam logic [15:0] DECAY_MS_RST   = 16'd100;
  localparam logic [15:0] SUSTAIN_RST    = 16'd22938;
  localparam logic [15:0] RELEASE_MS_RST = 16'd200;

  // Envelope and sample constants.
  localparam logic [15:0]        FULL_LEVEL   = 16'd32768;
  localparam logic [15:0]        CUTOFF_LEVEL = 16'd33;
  localparam logic signed [12:0] CENTER      = 13'sd2047;
  localparam logic signed [46:0] CENTER_Q30  = 47'sd2047 <<< 30;
  localparam logic [11:0]        SAMPLE_MAX  = 12'd4095;

  // Serial divider: two quotient bits per cycle over a 32-bit dividend.
  localparam int DIV_STEPS = 16;

  // Envelope stage codes as they appear on stage_now.
  typedef enum logic [2:0] {
    ENV_IDLE    = 3'd0,
    ENV_ATTACK  = 3'd1,
    ENV_DECAY   = 3'd2,
    ENV_SUSTAIN = 3'd3,
    ENV_RELEASE = 3'd4
  } env_stage_t;

  // Control sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_WAIT_IDX,
    S_WAIT_RD,
    S_PROD,
    S_DIV,
    S_LVL,
    S_MUL_GAIN,
    S_MUL_ENV,
    S_FIN,
    S_DONE
  } ctl_state_t;

  // Command transaction payload.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [9:0]  table_addr;
    logic [11:0] table_data;
  } voice_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [11:0] sample_out;
    logic        is_idle;
    logic [2:0]  stage_now;
  } voice_out_t;

endpackage

// ===== rtl/core/wavetable_voice_with_adsr.sv =====
// ----------------------------------------------------------------------------
// Wavetable voice with linear ADSR envelope
// Phase-accumulator oscillator reading a block-RAM wavetable, scaled by gain
// and by a linear attack/decay/sustain/release envelope.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the cmd channel (cmd_valid/cmd_stall/cmd_item) and each
// one produces exactly one transaction on the res channel (res_valid,
// res_stall, res_item). A command is taken when cmd_valid is high and
// cmd_stall is low; the block handles one command at a time.
// Note on, note off, tick and table write pass only through the command and
// done states. A sample request reads the table and forms the gain and
// envelope products; while a segment is sloping it first takes the slope,
// a quotient from a serial divider that yields two bits per cycle. In each
// case the result turns valid in the same cycle as the next command can be
// taken. The wavetable RAM has registered read data.
// The result sits in an output register; while res_stall holds it, the next
// command may be accepted and worked on, but its result waits in the
// sequencer until the output register is taken.
// Reset (rst, synchronous) restores the register defaults, idles the
// envelope and clears the phase and millisecond counters; the wavetable is
// not cleared and must be loaded with table writes before it is played.
// Configuration writes are only made while the block is idle: the user is bound to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module wavetable_voice_with_adsr
  import wvadsr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  voice_in_t  cmd_item,
  output logic       res_valid,
  input  logic       res_stall,
  output voice_out_t res_item,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = AW + 1;

  // Configuration registers.
  logic [31:0] phase_step;
  logic [15:0] gain;
  logic [15:0] attack_ms;
  logic [15:0] decay_ms;
  logic [15:0] sustain_level;
  logic [15:0] release_ms;

  // Voice state.
  env_stage_t  env_stage;
  logic [15:0] env_level;
  logic [15:0] seg_start_level;
  logic [15:0] seg_end_level;
  logic [31:0] phase_acc;
  logic [31:0] ms_now;
  logic [31:0] seg_start_ms;

  // Sequencer.
  ctl_state_t state;
  ctl_state_t state_next;
  voice_in_t  item;

  // Envelope slope working registers.
  logic        env_up;
  logic [15:0] env_diff;
  logic [15:0] env_dur;
  logic [15:0] el_lo;
  logic [31:0] div_num;
  logic [15:0] div_rem;
  logic [15:0] div_quo;
  logic [3:0]  div_cnt;

  // Wavetable memory and read pipeline.
  logic [11:0]   wave_mem [TABLE_DEPTH];
  logic [AW-1:0] rd_idx;
  logic [11:0]   rd_word;

  // Sample arithmetic.
  logic signed [29:0] p_gain;
  logic signed [46:0] p_env;
  logic [11:0]        smp;

  // Combinational helpers.
  logic [31:0]          el;
  logic [15:0]          sus_c;
  logic [15:0]          cur_dur;
  logic                 need_slope;
  logic [32+DW-1:0]     ph_mul;
  logic signed [12:0]   raw;
  logic signed [16:0]   gain_s;
  logic signed [16:0]   env_s;
  logic signed [29:0]   p_gain_w;
  logic signed [46:0]   p_env_w;
  logic signed [46:0]   v;
  logic [16:0]          r_a;
  logic [16:0]          r_a2;
  logic [16:0]          r_b;
  logic [16:0]          r_b2;
  logic                 q_a;
  logic                 q_b;
  logic                 res_free;
  logic                 tbl_wr_ok;

  // Envelope segment selection for the current stage.
  always_comb begin
    el      = ms_now - seg_start_ms;
    sus_c   = (sustain_level > FULL_LEVEL) ? FULL_LEVEL : sustain_level;
    cur_dur = 16'd0;
    case (env_stage)
      ENV_ATTACK:  cur_dur = attack_ms;
      ENV_DECAY:   cur_dur = decay_ms;
      ENV_RELEASE: cur_dur = release_ms;
      default:     cur_dur = 16'd0;
    endcase
    need_slope = (env_stage inside {ENV_ATTACK, ENV_DECAY, ENV_RELEASE}) &&
                 (el < {16'd0, cur_dur});
  end

  // Two restoring division steps per cycle.
  always_comb begin
    r_a  = {div_rem, div_num[31]};
    q_a  = (r_a >= {1'b0, env_dur});
    r_a2 = q_a ? (r_a - {1'b0, env_dur}) : r_a;
    r_b  = {r_a2[15:0], div_num[30]};
    q_b  = (r_b >= {1'b0, env_dur});
    r_b2 = q_b ? (r_b - {1'b0, env_dur}) : r_b;
  end

  // Table index, sample products and output clip.
  assign ph_mul    = phase_acc * DW'(TABLE_DEPTH);
  assign raw       = $signed({1'b0, rd_word}) - CENTER;
  assign gain_s    = $signed({1'b0, gain});
  assign env_s     = $signed({1'b0, env_level});
  assign p_gain_w  = raw * gain_s;
  assign p_env_w   = p_gain * env_s;
  assign v         = p_env + CENTER_Q30;
  assign tbl_wr_ok = ({22'd0, item.table_addr} < 32'(TABLE_DEPTH));
  assign res_free  = !res_valid || !res_stall;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and handshake.
  always_comb begin
    state_next = state;
    cmd_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_CMD;
      end
      S_CMD: begin
        if (item.cmd == CMD_SAMPLE) begin
          state_next = need_slope ? S_PROD : S_WAIT_IDX;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WAIT_IDX: state_next = S_WAIT_RD;
      S_WAIT_RD:  state_next = S_MUL_GAIN;
      S_PROD:     state_next = S_DIV;
      S_DIV: begin
        if (div_cnt == 4'(DIV_STEPS - 1)) state_next = S_LVL;
      end
      S_LVL:      state_next = S_MUL_GAIN;
      S_MUL_GAIN: state_next = S_MUL_ENV;
      S_MUL_ENV:  state_next = S_FIN;
      S_FIN:      state_next = S_DONE;
      S_DONE: begin
        if (res_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= PHASE_STEP_RST;
      gain          <= GAIN_RST;
      attack_ms     <= ATTACK_MS_RST;
      decay_ms      <= DECAY_MS_RST;
      sustain_level <= SUSTAIN_RST;
      release_ms    <= RELEASE_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_STEP: phase_step    <= cfg_data;
        REG_GAIN:       gain          <= cfg_data[15:0];
        REG_ATTACK_MS:  attack_ms     <= cfg_data[15:0];
        REG_DECAY_MS:   decay_ms      <= cfg_data[15:0];
        REG_SUSTAIN:    sustain_level <= cfg_data[15:0];
        REG_RELEASE_MS: release_ms    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Wavetable: write on table write commands, read continuously at the
  // registered index derived from the phase accumulator.
  always_ff @(posedge clk) begin
    if (state == S_CMD && item.cmd == CMD_TBL_WR && tbl_wr_ok) begin
      wave_mem[AW'({22'd0, item.table_addr})] <= item.table_data;
    end
    rd_idx  <= ph_mul[32+AW-1:32];
    rd_word <= wave_mem[rd_idx];
  end

  // Voice state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      env_stage       <= ENV_IDLE;
      env_level       <= 16'd0;
      seg_start_level <= 16'd0;
      seg_end_level   <= 16'd0;
      phase_acc       <= 32'd0;
      ms_now          <= 32'd0;
      seg_start_ms    <= 32'd0;
    end else begin
      case (state)
        S_CMD: begin
          case (item.cmd)
            CMD_SAMPLE: begin
              phase_acc <= phase_acc + phase_step;
              case (env_stage)
                ENV_ATTACK: begin
                  if (!need_slope) begin
                    env_level       <= seg_end_level;
                    env_stage       <= ENV_DECAY;
                    seg_start_level <= seg_end_level;
                    seg_end_level   <= sus_c;
                    seg_start_ms    <= ms_now;
                  end
                end
                ENV_DECAY: begin
                  if (!need_slope) begin
                    env_level <= seg_end_level;
                    env_stage <= ENV_SUSTAIN;
                  end
                end
                ENV_SUSTAIN: env_level <= sus_c;
                ENV_RELEASE: begin
                  if (!need_slope) begin
                    env_level <= 16'd0;
                    env_stage <= ENV_IDLE;
                  end
                end
                default: begin
                  env_level <= 16'd0;
                  env_stage <= ENV_IDLE;
                end
              endcase
            end
            CMD_NOTE_ON: begin
              env_stage       <= ENV_ATTACK;
              env_level       <= 16'd0;
              seg_start_level <= 16'd0;
              seg_end_level   <= FULL_LEVEL;
              seg_start_ms    <= ms_now;
            end
            CMD_NOTE_OFF: begin
              if (env_stage != ENV_IDLE && env_stage != ENV_RELEASE) begin
                env_stage       <= ENV_RELEASE;
                seg_start_level <= env_level;
                seg_end_level   <= 16'd0;
                seg_start_ms    <= ms_now;
              end
            end
            CMD_TICK: ms_now <= ms_now + 32'd1;
            default: ;
          endcase
        end
        S_LVL: begin
          env_level <= env_up ? (seg_start_level + div_quo)
                              : (seg_start_level - div_quo);
        end
        S_FIN: begin
          // A release that has faded below the audible floor ends here.
          if (env_stage == ENV_RELEASE && env_level < CUTOFF_LEVEL) begin
            env_stage <= ENV_IDLE;
            env_level <= 16'd0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers: command latch, slope divider and sample products.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      item <= cmd_item;
    end
    case (state)
      S_CMD: begin
        smp     <= 12'd0;
        env_up  <= (seg_end_level >= seg_start_level);
        env_diff <= (seg_end_level >= seg_start_level) ?
                    (seg_end_level - seg_start_level) :
                    (seg_start_level - seg_end_level);
        env_dur <= cur_dur;
        el_lo   <= el[15:0];
      end
      S_PROD: begin
        div_num <= env_diff * el_lo;
        div_rem <= 16'd0;
        div_quo <= 16'd0;
        div_cnt <= 4'd0;
      end
      S_DIV: begin
        div_num <= {div_num[29:0], 2'b00};
        div_rem <= r_b2[15:0];
        div_quo <= {div_quo[13:0], q_a, q_b};
        div_cnt <= div_cnt + 4'd1;
      end
      S_MUL_GAIN: p_gain <= p_gain_w;
      S_MUL_ENV:  p_env  <= p_env_w;
      S_FIN: begin
        if (v[46]) begin
          smp <= 12'd0;
        end else if (|v[45:42]) begin
          smp <= SAMPLE_MAX;
        end else begin
          smp <= v[41:30];
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded when the sequencer finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && res_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && res_free) begin
      res_item.sample_out <= smp;
      res_item.is_idle    <= (env_stage == ENV_IDLE);
      res_item.stage_now  <= env_stage;
    end
  end

  // The envelope never rises above full scale.
  a_level_max: assert property (@(posedge clk) disable iff (rst)
    env_level <= FULL_LEVEL)
    else $error("envelope level above full scale");

  // An idle envelope rests at zero between transactions.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && env_stage == ENV_IDLE) |-> env_level == 16'd0)
    else $error("idle envelope with non-zero level");

  // The slope quotient never exceeds the level difference.
  a_quo_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_LVL) |-> div_quo <= env_diff)
    else $error("slope quotient exceeds segment span");

  // The partial remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != 4'd0) |-> div_rem < env_dur)
    else $error("divider remainder out of range");

  // A new result only appears when the sequencer has finished a command.
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> $past(state) == S_DONE)
    else $error("result without completed command");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Wavetable voice testbench
// Drives command transactions into the voice and compares every result
// transaction with a cycle-free model of the oscillator and its envelope.
// A short directed sequence covers table extremes, spare commands,
// zero-length segments, a sustain above full scale, note restarts and the
// release cut-off. It is followed by eight randomised phases of note
// sequences and noise. Each phase has its own register settings; its mix of
// sender gaps and receiver back-pressure is one of four, taken in turn.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wvadsr_pkg::*;

  localparam int DEPTH           = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 190;
  localparam int SETTLE_CYCLES   = 40;

  // Command codes that the voice ignores.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // Expected-result store with its own copy of the voice state.
  class voice_scoreboard;
    bit [31:0]  phase_step;
    bit [15:0]  gain, attack_ms, decay_ms, sustain_lvl, release_ms;
    bit [11:0]  wave_mem [DEPTH];
    bit [31:0]  phase_acc, ms_now, seg_start_ms;
    env_stage_t stage;
    bit [15:0]  level, seg_start_lvl, seg_end_lvl;
    voice_out_t awaited_results [$];
    int         error_count;

    function new();
      phase_step  = PHASE_STEP_RST;
      gain        = GAIN_RST;
      attack_ms   = ATTACK_MS_RST;
      decay_ms    = DECAY_MS_RST;
      sustain_lvl = SUSTAIN_RST;
      release_ms  = RELEASE_MS_RST;
      stage       = ENV_IDLE;
      error_count = 0;
    endfunction

    function void write_register(logic [2:0] index, logic [31:0] value);
      case (index)
        REG_PHASE_STEP: phase_step = value;
        REG_GAIN:       gain = value[15:0];
        REG_ATTACK_MS:  attack_ms = value[15:0];
        REG_DECAY_MS:   decay_ms = value[15:0];
        REG_SUSTAIN:    sustain_lvl = value[15:0];
        REG_RELEASE_MS: release_ms = value[15:0];
        default: ;
      endcase
    endfunction

    // A sustain setting above full scale behaves as full scale.
    function bit [15:0] sustain_target();
      return (sustain_lvl > FULL_LEVEL) ? FULL_LEVEL : sustain_lvl;
    endfunction

    // Linear point between the segment ends; the quotient truncates.
    function bit [15:0] slope_level(bit [31:0] elapsed, bit [15:0] dur);
      longint unsigned span;
      longint unsigned delta;
      if (seg_end_lvl >= seg_start_lvl) begin
        span  = seg_end_lvl - seg_start_lvl;
        delta = span * elapsed / dur;
        return seg_start_lvl + delta[15:0];
      end
      span  = seg_start_lvl - seg_end_lvl;
      delta = span * elapsed / dur;
      return seg_start_lvl - delta[15:0];
    endfunction

    // Envelope update made at the start of every sample request.
    function bit [15:0] envelope_level();
      bit [31:0] elapsed;
      elapsed = ms_now - seg_start_ms;
      case (stage)
        ENV_ATTACK: begin
          if (elapsed < attack_ms) begin
            level = slope_level(elapsed, attack_ms);
          end else begin
            level         = seg_end_lvl;
            stage         = ENV_DECAY;
            seg_start_lvl = seg_end_lvl;
            seg_end_lvl   = sustain_target();
            seg_start_ms  = ms_now;
          end
        end
        ENV_DECAY: begin
          if (elapsed < decay_ms) begin
            level = slope_level(elapsed, decay_ms);
          end else begin
            level = seg_end_lvl;
            stage = ENV_SUSTAIN;
          end
        end
        ENV_SUSTAIN: begin
          level = sustain_target();
        end
        ENV_RELEASE: begin
          if (elapsed < release_ms) begin
            level = slope_level(elapsed, release_ms);
          end else begin
            stage = ENV_IDLE;
            level = '0;
          end
        end
        default: begin
          stage = ENV_IDLE;
          level = '0;
        end
      endcase
      return level;
    endfunction

    // One DAC sample: oscillator word scaled by gain and envelope.
    function bit [11:0] dac_value();
      bit [15:0]       env;
      longint unsigned pos;
      longint          centred;
      longint          acc;
      bit [11:0]       result;
      env       = envelope_level();
      phase_acc = phase_acc + phase_step;
      pos       = (longint'(phase_acc) * DEPTH) >> 32;
      if (pos >= DEPTH) begin
        pos = DEPTH - 1;
      end
      centred = longint'(wave_mem[pos]) - longint'(CENTER);
      acc = centred * longint'(gain) * longint'(env) + (longint'(CENTER) <<< 30);
      if (acc < 0) begin
        result = '0;
      end else begin
        acc    = acc >>> 30;
        result = (acc > SAMPLE_MAX) ? SAMPLE_MAX : acc[11:0];
      end
      // A release that has faded below the cut-off ends the note at once.
      if (stage == ENV_RELEASE && env < CUTOFF_LEVEL) begin
        stage = ENV_IDLE;
        level = '0;
      end
      return result;
    endfunction

    // Applies one command to the voice state and returns its result.
    function voice_out_t run_command(voice_in_t c);
      voice_out_t r;
      r.sample_out = '0;
      case (c.cmd)
        CMD_SAMPLE: begin
          r.sample_out = dac_value();
        end
        CMD_NOTE_ON: begin
          stage         = ENV_ATTACK;
          level         = '0;
          seg_start_lvl = '0;
          seg_end_lvl   = FULL_LEVEL;
          seg_start_ms  = ms_now;
        end
        CMD_NOTE_OFF: begin
          if (stage != ENV_IDLE && stage != ENV_RELEASE) begin
            stage         = ENV_RELEASE;
            seg_start_lvl = level;
            seg_end_lvl   = '0;
            seg_start_ms  = ms_now;
          end
        end
        CMD_TICK: begin
          ms_now = ms_now + 1;
        end
        CMD_TBL_WR: begin
          if (c.table_addr < DEPTH) begin
            wave_mem[c.table_addr] = c.table_data;
          end
        end
        default: ;
      endcase
      r.is_idle   = (stage == ENV_IDLE);
      r.stage_now = stage;
      return r;
    endfunction

    function void note_command(voice_in_t c);
      awaited_results.push_back(run_command(c));
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_result(voice_out_t got);
      voice_out_t want;
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result transaction: expected none, actual %p",
                 $time, got);
        return;
      end
      want = awaited_results.pop_front();
      if (got.sample_out !== want.sample_out) begin
        flag("sample_out", want.sample_out, got.sample_out);
      end
      if (got.is_idle !== want.is_idle) begin
        flag("is_idle", want.is_idle, got.is_idle);
      end
      if (got.stage_now !== want.stage_now) begin
        flag("stage_now", want.stage_now, got.stage_now);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  voice_in_t   cmd_item = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  voice_out_t  res_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  voice_scoreboard sb;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          res_stall_pct = 0;
  int          useful_items = 0;
  // Sender-side copy of the phase, so that no sample reads an unloaded word.
  bit [31:0]   phase_track = '0;
  bit [31:0]   step_track = PHASE_STEP_RST;
  bit          table_loaded [DEPTH];

  wavetable_voice_with_adsr #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random back-pressure on the result channel.
  always @(posedge clk) begin
    res_stall <= (res_stall_pct != 0) && ($urandom_range(0, 99) < res_stall_pct);
  end

  // Transaction monitor on both channels.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        sb.note_command(cmd_item);
      end
      if (res_valid && !res_stall) begin
        sb.check_result(res_item);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Presents one command and holds it until the voice takes it.
  task automatic push_item(input voice_in_t it);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    if (it.cmd == CMD_TBL_WR) begin
      table_loaded[it.table_addr] = 1'b1;
    end
    if (it.cmd <= CMD_TBL_WR) begin
      useful_items++;
    end
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic load_word(input logic [9:0] addr, input logic [11:0] data);
    voice_in_t it;
    it.cmd        = CMD_TBL_WR;
    it.table_addr = addr;
    it.table_data = data;
    push_item(it);
  endtask

  // Sends a command with random fields; a sample request about to read an
  // unloaded word is preceded by a write of that word.
  task automatic issue(input logic [2:0] op);
    voice_in_t it;
    bit [31:0] next_phase;
    int        idx;
    it.cmd        = op;
    it.table_addr = 10'($urandom);
    it.table_data = 12'($urandom);
    if (op == CMD_SAMPLE) begin
      next_phase = phase_track + step_track;
      idx        = int'((longint'(next_phase) * DEPTH) >> 32);
      if (!table_loaded[idx]) begin
        load_word(10'(idx), 12'($urandom));
      end
      phase_track = next_phase;
    end
    push_item(it);
  endtask

  // Holds the sender off until every result has been taken. The first edge
  // lets the monitor record a transaction accepted at the current edge.
  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    sb.write_register(index, value);
    if (index == REG_PHASE_STEP) begin
      step_track = value;
    end
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] step, input logic [15:0] amp,
                                input logic [15:0] att, input logic [15:0] dec,
                                input logic [15:0] sus, input logic [15:0] rel);
    drain();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_GAIN, 32'(amp));
    write_reg(REG_ATTACK_MS, 32'(att));
    write_reg(REG_DECAY_MS, 32'(dec));
    write_reg(REG_SUSTAIN, 32'(sus));
    write_reg(REG_RELEASE_MS, 32'(rel));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] short_duration();
    return 16'($urandom_range(0, 20));
  endfunction

  // Mostly ticks and samples, with the odd write, stray note or spare code.
  task automatic body_step();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      issue(CMD_TICK);
    end else if (pick < 88) begin
      issue(CMD_SAMPLE);
    end else if (pick < 93) begin
      issue(CMD_TBL_WR);
    end else if (pick < 96) begin
      issue(pick[0] ? CMD_NOTE_ON : CMD_NOTE_OFF);
    end else begin
      issue(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
    end
  endtask

  // One well-formed note: on, a held stretch, off, and a tail.
  task automatic play_note();
    int hold;
    int tail;
    hold = $urandom_range(0, 40);
    tail = $urandom_range(0, 40);
    issue(CMD_NOTE_ON);
    repeat (hold) body_step();
    issue(CMD_NOTE_OFF);
    repeat (tail) body_step();
  endtask

  initial begin
    int target;
    bit paused;
    voice_in_t spare;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero-length segments, full gain and a sustain above full.
    apply_settings('0, 16'hFFFF, '0, '0, 16'd40000, '0);
    load_word('0, 12'hFFF);
    load_word(10'(DEPTH - 1), '0);
    for (int op = CMD_SPARE_FIRST; op <= CMD_SPARE_LAST; op++) begin
      spare = '1;
      spare.cmd = 3'(op);
      push_item(spare);
    end
    issue(CMD_NOTE_OFF);
    issue(CMD_SAMPLE);
    issue(CMD_NOTE_ON);
    issue(CMD_SAMPLE);
    issue(CMD_SAMPLE);
    issue(CMD_SAMPLE);
    load_word('0, '0);
    issue(CMD_SAMPLE);
    issue(CMD_NOTE_ON);
    issue(CMD_NOTE_OFF);
    issue(CMD_SAMPLE);
    issue(CMD_NOTE_ON);
    issue(CMD_SAMPLE);
    issue(CMD_NOTE_OFF);
    issue(CMD_NOTE_OFF);
    issue(CMD_TICK);
    issue(CMD_SAMPLE);
    // A release that starts from silence is cut off by its first sample.
    apply_settings(PHASE_STEP_RST, GAIN_RST, ATTACK_MS_RST, DECAY_MS_RST,
                   SUSTAIN_RST, RELEASE_MS_RST);
    issue(CMD_NOTE_ON);
    issue(CMD_NOTE_OFF);
    issue(CMD_SAMPLE);

    // Randomised phases.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings($urandom, GAIN_RST, short_duration(), short_duration(),
                          16'($urandom_range(0, 32768)), short_duration());
        1: apply_settings($urandom_range(0, 1 << 22), 16'($urandom), short_duration(),
                          short_duration(), 16'($urandom_range(0, 32768)),
                          short_duration());
        2: apply_settings(32'hFFFF_FFFF, 16'hFFFF, '0, '0, 16'hFFFF, '0);
        3: apply_settings('0, '0, 16'hFFFF, 16'hFFFF, '0, 16'hFFFF);
        4: apply_settings($urandom, 16'($urandom), short_duration(), short_duration(),
                          FULL_LEVEL, short_duration());
        5: apply_settings($urandom, GAIN_RST, ATTACK_MS_RST, DECAY_MS_RST,
                          SUSTAIN_RST, RELEASE_MS_RST);
        6: apply_settings($urandom, 16'($urandom), short_duration(), short_duration(),
                          16'($urandom), short_duration());
        default: apply_settings(32'h0040_0000, GAIN_RST, 16'd1, 16'd1, 16'd16384, 16'd1);
      endcase
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          res_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          res_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          res_stall_pct = 63;
        end
        default: begin
          send_idle_pct = 25;
          res_stall_pct = 25;
        end
      endcase
      target = useful_items + ITEMS_PER_PHASE;
      paused = 1'b0;
      while (useful_items < target) begin
        // Half-way through, let the voice empty out completely.
        if (!paused && useful_items >= target - ITEMS_PER_PHASE / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 85) begin
          play_note();
        end else begin
          issue(3'($urandom_range(0, 7)));
        end
      end
    end

    // Wind down and report.
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.awaited_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/wvadsr_pkg.sv
rtl/core/wavetable_voice_with_adsr.sv
bench/tb_top.sv
